// ----- hdl/max_heap_priority_queue_assert.svh -----
// Assertion macros for the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Concurrent check, masked while reset is asserted.
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check that also holds across reset.
`define MHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int VAL_W    = 32;
    localparam int ENTRY_W  = 11;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        t_status                 status;
        logic [ENTRY_W-1:0]      entry_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_CMP,
        S_REM_LOAD,
        S_REM_CHK,
        S_REM_CMP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    ins_init;
        logic    ins_read;
        logic    ins_move;
        logic    ins_place;
        logic    rem_read0;
        logic    rem_load;
        logic    rem_read;
        logic    rem_move;
        logic    rem_place;
        logic    set_status;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
        logic k_zero;
        logic parent_less;
        logic last_one;
        logic child_in_range;
        logic moving_less;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- hdl/mhpq_datapath.sv -----
// Heap storage, index/count registers and compare logic.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mhpq_pkg::t_in       i_item,
    input  mhpq_pkg::t_cmd      i_cmd,
    output mhpq_pkg::t_dp_stat  o_stat,
    output mhpq_pkg::t_out      o_result
);
    import mhpq_pkg::*;

    logic signed [VAL_W-1:0] r_heap_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_a;
    logic signed [VAL_W-1:0] r_rd_b;
    logic signed [VAL_W-1:0] r_val;      // value being inserted or sifted down
    logic signed [VAL_W-1:0] r_removed;
    logic [ADDR_W-1:0]       r_k;        // current hole index
    logic [CNT_W-1:0]        r_count;
    t_op                     r_op;
    t_status                 r_status;

    logic                    re_a;
    logic                    re_b;
    logic [ADDR_W-1:0]       addr_a;
    logic [ADDR_W-1:0]       addr_b;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic signed [VAL_W-1:0] wdata;

    logic [ADDR_W-1:0]       parent;
    logic [CHILD_W-1:0]      c_left;
    logic [CHILD_W-1:0]      c_right;
    logic [CHILD_W-1:0]      n_ext;
    logic                    use_right;
    logic signed [VAL_W-1:0] child_val;
    logic [ADDR_W-1:0]       child_idx;

    assign parent    = (r_k - 1'b1) >> 1;
    assign c_left    = {1'b0, r_k, 1'b1};
    assign c_right   = c_left + CHILD_W'(1);
    assign n_ext     = CHILD_W'(r_count);
    assign use_right = (c_right < n_ext) && (r_rd_a < r_rd_b);   // left wins a tie
    assign child_val = use_right ? r_rd_b : r_rd_a;
    assign child_idx = use_right ? c_right[ADDR_W-1:0] : c_left[ADDR_W-1:0];

    always_comb begin
        re_a   = 1'b0;
        re_b   = 1'b0;
        addr_a = parent;
        addr_b = ADDR_W'(r_count - 1'b1);
        we     = 1'b0;
        waddr  = r_k;
        wdata  = r_val;
        if (i_cmd.ins_read) begin
            re_a = 1'b1;
        end
        if (i_cmd.rem_read0) begin
            re_a   = 1'b1;
            re_b   = 1'b1;
            addr_a = '0;
        end
        if (i_cmd.rem_read) begin
            re_a   = 1'b1;
            re_b   = 1'b1;
            addr_a = c_left[ADDR_W-1:0];
            addr_b = c_right[ADDR_W-1:0];
        end
        if (i_cmd.ins_move) begin
            we    = 1'b1;
            wdata = r_rd_a;
        end
        if (i_cmd.rem_move) begin
            we    = 1'b1;
            wdata = child_val;
        end
        if (i_cmd.ins_place || i_cmd.rem_place) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_heap_mem[waddr] <= wdata;
        end
        if (re_a) begin
            r_rd_a <= r_heap_mem[addr_a];
        end
        if (re_b) begin
            r_rd_b <= r_heap_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_place) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.rem_load) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_item.op;
            r_val     <= i_item.value;
            r_removed <= '0;
            r_status  <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.ins_init) begin
            r_k <= r_count[ADDR_W-1:0];
        end
        if (i_cmd.ins_move) begin
            r_k <= parent;
        end
        if (i_cmd.rem_load) begin
            r_k       <= '0;
            r_val     <= r_rd_b;
            r_removed <= r_rd_a;
        end
        if (i_cmd.rem_move) begin
            r_k <= child_idx;
        end
    end

    assign o_stat.op_remove      = (r_op == OP_REMOVE);
    assign o_stat.full           = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.empty          = (r_count == '0);
    assign o_stat.k_zero         = (r_k == '0);
    assign o_stat.parent_less    = (r_rd_a < r_val);
    assign o_stat.last_one       = (r_count == CNT_W'(1));
    assign o_stat.child_in_range = (c_left < n_ext);
    assign o_stat.moving_less    = (r_val < child_val);

    assign o_result.removed_value = r_removed;
    assign o_result.status        = r_status;
    assign o_result.entry_count   = ENTRY_W'(r_count);

endmodule
`default_nettype wire

// ----- hdl/mhpq_ctrl.sv -----
// Sequencer for insert / remove-maximum operations.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  mhpq_pkg::t_dp_stat  i_stat,
    output mhpq_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    import mhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.op_remove) begin
                    if (i_stat.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.ins_init = 1'b1;
                        n_state        = S_INS_CHK;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_EMPTY;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.rem_read0 = 1'b1;
                        n_state         = S_REM_LOAD;
                    end
                end
            end
            S_INS_CHK: begin
                if (i_stat.k_zero) begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.ins_read = 1'b1;
                    n_state        = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.parent_less) begin
                    o_cmd.ins_move = 1'b1;
                    n_state        = S_INS_CHK;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_REM_LOAD: begin
                o_cmd.rem_load = 1'b1;
                n_state        = i_stat.last_one ? S_DONE : S_REM_CHK;
            end
            S_REM_CHK: begin
                if (i_stat.child_in_range) begin
                    o_cmd.rem_read = 1'b1;
                    n_state        = S_REM_CMP;
                end else begin
                    o_cmd.rem_place = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_REM_CMP: begin
                if (i_stat.moving_less) begin
                    o_cmd.rem_move = 1'b1;
                    n_state        = S_REM_CHK;
                end else begin
                    o_cmd.rem_place = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
`include "max_heap_priority_queue_assert.svh"
// Usage
//   Command channel: an item (op, value) transfers on a rising edge with start
//   high and busy low. op insert pushes value, op remove pops the maximum.
//   Result channel: o_done is high for exactly one cycle with o_result valid
//   (removed_value, status, entry_count). The receiver cannot stall; the
//   result must be taken in that cycle. busy stays high from the transfer
//   until the cycle after the strobe, so one item is worked at a time.
// Operation
//   Insert: the value climbs from the new last slot toward the root, up to 10
//   levels; it is placed at the root or below the first parent not less than it.
//   Remove: the root and the last entry are read together; if the root is the
//   only entry the remove ends there, else the last entry sinks from the root
//   until it has no child in range or is not less than the larger child.
//   A full insert or an empty remove only sets the status and moves no entry.
//   Each heap level costs a memory read step plus a compare-and-write step;
//   the heap RAM has one write port and two registered read ports, the two
//   reads fetching both children at once during sift-down.
// Reset
//   Synchronous active-low reset clears the entry count and the sequencer.
//   The heap RAM is not cleared; only entries below the count are used.
module max_heap_priority_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  mhpq_pkg::t_in   i_item,
    output logic            o_done,
    output mhpq_pkg::t_out  o_result
);
    import mhpq_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    mhpq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    // A transfer always starts a busy period.
    `MHPQ_ASSERT(a_start_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "transfer did not set busy")
    // After the result strobe the block is ready again.
    `MHPQ_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |=> !busy, "busy after result strobe")
    // A rejected insert only happens at capacity.
    `MHPQ_ASSERT(a_full_count, i_clk, i_rst_n,
        (o_done && o_result.status == ST_FULL) |-> (o_result.entry_count == ENTRY_W'(CAPACITY)),
        "full status with count below capacity")
    // An empty remove reports a zero value and an empty heap.
    `MHPQ_ASSERT(a_empty_zero, i_clk, i_rst_n,
        (o_done && o_result.status == ST_EMPTY) |->
            (o_result.entry_count == '0 && o_result.removed_value == '0),
        "empty status with nonzero count or value")
    // No result strobe right after a reset edge.
    `MHPQ_ASSERT_ALWAYS(a_rst_no_done, i_clk, !i_rst_n |=> !o_done, "result strobe after reset")

endmodule
`default_nettype wire
